>>> src/smd_pkg.sv
// Package for the syncmer detector: item types, sizes and hash helpers.
package smd_pkg;

  localparam int MaxKmer    = 64;
  localparam int IdxW       = $clog2(MaxKmer);
  localparam int LenW       = 7;
  localparam int OffW       = 6;
  localparam int PosW       = 32;
  localparam int HashW      = 64;
  localparam int BaseW      = 4;
  localparam int CfgIdxW    = 2;
  localparam int TreeLevels = IdxW;

  localparam logic [HashW-1:0] SeedBase = 64'h9ae16a3b2f90404f;

  localparam logic [CfgIdxW-1:0] CfgKmerLen    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSmerLen    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSyncOffset = 2'd2;

  typedef struct packed {
    logic [BaseW-1:0] base_code;
    logic             start_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]  kmer_position;
    logic [HashW-1:0] min_smer_hash;
  } out_item_t;

  // One candidate of the minimum search: distance back from the newest s-mer.
  typedef struct packed {
    logic             valid;
    logic [IdxW-1:0]  lag;
    logic [HashW-1:0] hash;
  } cand_t;

  typedef struct packed {
    logic            valid;
    logic            ok;
    logic [PosW-1:0] pos;
    logic [LenW-1:0] span;
  } meta_t;

  function automatic logic [HashW-1:0] rol1(input logic [HashW-1:0] x);
    rol1 = {x[HashW-2:0], x[HashW-1]};
  endfunction

  function automatic logic [HashW-1:0] seed_of(input logic [BaseW-1:0] n);
    seed_of = SeedBase ^ {{(HashW-BaseW){1'b0}}, n};
  endfunction

endpackage

>>> src/smd_cell.sv
// One cell of the window chain: holds a base and the hash of the s-mer ending there.
module smd_cell
  import smd_pkg::*;
(
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [BaseW-1:0] base_i,
  input  logic [HashW-1:0] hash_i,
  output logic [BaseW-1:0] base_o,
  output logic [HashW-1:0] hash_o
);

  logic [BaseW-1:0] base_q;
  logic [HashW-1:0] hash_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      base_q <= base_i;
      hash_q <= hash_i;
    end
  end

  assign base_o = base_q;
  assign hash_o = hash_q;

endmodule

>>> src/smd_min_node.sv
// Registered node of the minimum tree; the left input is the newer candidate.
module smd_min_node
  import smd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cand_t left_i,
  input  cand_t right_i,
  output cand_t cand_o
);

  cand_t cand_q, cand_d;

  // Ties go to the newer s-mer, which is the rightmost one in the k-mer.
  always_comb begin
    if (left_i.valid && (!right_i.valid || (left_i.hash <= right_i.hash))) begin
      cand_d = left_i;
    end else begin
      cand_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else if (en_i) begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

>>> src/syncmer_detector.sv
// Top level of the open-syncmer detector: hash roll, cell chain and minimum tree.
//
// Usage: each input item carries one 4-bit base and a start flag that marks
// index 0 of a new sequence. The block rolls a 64-bit s-mer hash per base and,
// once a whole k-mer of the current sequence has arrived, reports the k-mer's
// start index and its minimal s-mer hash when that minimum sits at the
// programmed offset. Each item gives zero or one result item.
// Configuration: kmer_len, smer_len and sync_offset are written through the
// cfg channel (index 0, 1, 2; higher indexes are ignored); the user must do so
// while the block is idle; it does not enforce this. cfg_ready_o is always high.
// Throughput: one item per cycle while no result is held by out_stall_i. The
// hashes live in a chain of 64 cells that shifts once per accepted item; the
// minimum over the window is found by a six-level registered compare tree.
// A result passes the cell chain, the tree levels and the output register
// before it shows on out_valid_o.
// Stall: while out_stall_i holds a valid result, the whole pipeline freezes
// and in_stall_o is raised; the result stays put until taken.
// Reset: registers return to k=15, s=11, offset 2; hash, index and fill clear.
module syncmer_detector
  import smd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenW-1:0]    cfg_data_i
);

  logic [LenW-1:0] kmer_len_q, smer_len_q;
  logic [OffW-1:0] sync_offset_q;

  logic [HashW-1:0] hash_q, hash_d, hash_base;
  logic [PosW-1:0]  count_q, count_eff;
  logic [LenW-1:0]  fill_q, fill_eff, fill_d;

  logic advance, accept;
  logic out_valid_q;
  out_item_t out_item_q;

  logic [BaseW-1:0] cell_base [MaxKmer];
  logic [HashW-1:0] cell_hash [MaxKmer];
  logic [BaseW-1:0] out_base;
  logic [IdxW-1:0]  back_sel;

  meta_t meta_q [TreeLevels+1];
  meta_t meta_d;
  cand_t node [1:2*MaxKmer-1];
  logic  emit;

  // The whole pipeline moves together unless a finished result is held.
  assign advance    = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && advance;
  assign in_stall_o = !advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q    <= LenW'(15);
      smer_len_q    <= LenW'(11);
      sync_offset_q <= OffW'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgKmerLen:    kmer_len_q    <= cfg_data_i;
        CfgSmerLen:    smer_len_q    <= cfg_data_i;
        CfgSyncOffset: sync_offset_q <= cfg_data_i[OffW-1:0];
        default: ;
      endcase
    end
  end

  // A start flag restarts the hash, the index and the fill before the base
  // is taken; the chain itself keeps its old contents.
  assign hash_base = in_item_i.start_of_sequence ? '0 : hash_q;
  assign count_eff = in_item_i.start_of_sequence ? '0 : count_q;
  assign fill_eff  = in_item_i.start_of_sequence ? '0 : fill_q;
  assign fill_d    = (fill_eff < LenW'(MaxKmer)) ? fill_eff + LenW'(1) : fill_eff;

  // Cell i of the chain holds the base seen i+1 items ago, so the base
  // leaving an s-mer of length s is in cell s-1.
  assign back_sel = smer_len_q[IdxW-1:0] - IdxW'(1);

  always_comb begin
    if (smer_len_q == '0) begin
      out_base = in_item_i.base_code;
    end else if ((smer_len_q <= LenW'(MaxKmer)) && (fill_eff >= smer_len_q)) begin
      out_base = cell_base[back_sel];
    end else begin
      out_base = '0;
    end
  end

  assign hash_d = rol1(hash_base) ^ seed_of(out_base) ^ rol1(seed_of(in_item_i.base_code));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      count_q <= '0;
      fill_q  <= '0;
    end else if (accept) begin
      hash_q  <= hash_d;
      count_q <= count_eff + PosW'(1);
      fill_q  <= fill_d;
    end
  end

  // The chain of cells: the newest s-mer enters cell 0 and all others move
  // one cell further back.
  for (genvar c = 0; c < MaxKmer; c++) begin : g_cell
    if (c == 0) begin : g_head
      smd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .base_i  (in_item_i.base_code),
        .hash_i  (hash_d),
        .base_o  (cell_base[c]),
        .hash_o  (cell_hash[c])
      );
    end else begin : g_body
      smd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .base_i  (cell_base[c-1]),
        .hash_i  (cell_hash[c-1]),
        .base_o  (cell_base[c]),
        .hash_o  (cell_hash[c])
      );
    end
  end

  // Per-item facts that travel beside the tree.
  always_comb begin
    meta_d.valid = accept;
    meta_d.ok    = (smer_len_q != '0) && (smer_len_q <= kmer_len_q) &&
                   (kmer_len_q <= LenW'(MaxKmer)) && (fill_d >= kmer_len_q);
    meta_d.pos   = count_eff - PosW'(kmer_len_q) + PosW'(1);
    meta_d.span  = kmer_len_q - smer_len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l <= TreeLevels; l++) begin
        meta_q[l] <= '0;
      end
    end else if (advance) begin
      meta_q[0] <= meta_d;
      for (int l = 1; l <= TreeLevels; l++) begin
        meta_q[l] <= meta_q[l-1];
      end
    end
  end

  // Leaves of the tree: a cell takes part when it lies inside the k-mer.
  for (genvar d = 0; d < MaxKmer; d++) begin : g_leaf
    assign node[MaxKmer+d].valid = ({1'b0, IdxW'(d)} <= meta_q[0].span);
    assign node[MaxKmer+d].lag   = IdxW'(d);
    assign node[MaxKmer+d].hash  = cell_hash[d];
  end

  for (genvar n = 1; n < MaxKmer; n++) begin : g_node
    smd_min_node u_node (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .left_i  (node[2*n]),
      .right_i (node[2*n+1]),
      .cand_o  (node[n])
    );
  end

  // The minimum sits at offset span - lag from the k-mer's start.
  assign emit = meta_q[TreeLevels].valid && meta_q[TreeLevels].ok && node[1].valid &&
                (({1'b0, node[1].lag} + {1'b0, sync_offset_q}) == meta_q[TreeLevels].span);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_item_q.kmer_position <= meta_q[TreeLevels].pos;
      out_item_q.min_smer_hash <= node[1].hash;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LenW'(MaxKmer))
    else $error("fill count beyond chain length");

  a_root_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q[TreeLevels].valid && meta_q[TreeLevels].ok |-> node[1].valid)
    else $error("minimum tree lost every candidate of a full k-mer");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(meta_q[TreeLevels].valid && meta_q[TreeLevels].ok))
    else $error("result without a completed k-mer behind it");

  a_hold_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(hash_q) && $stable(count_q))
    else $error("hash state moved while the pipeline was held");
`endif

endmodule
